// ===== hdl/blm_pkg.sv =====
// ----------------------------------------------------------------------------
// blm_pkg: shared types and constants for the battery level monitor
// Field widths, configuration layout, reset values and result packing.
// ----------------------------------------------------------------------------
`default_nettype none

package blm_pkg;

    localparam int ADC_W       = 12;
    localparam int MV_W        = 16;
    localparam int LVL_W       = 3;
    localparam int HYST_W      = 12;
    localparam int NUM_LEVELS  = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    typedef logic [MV_W-1:0]  t_mv;
    typedef logic [LVL_W-1:0] t_lvl;

    localparam t_mv  MV_MAX        = '1;
    localparam t_mv  MIN_VALID_MV  = 16'd500;
    localparam t_lvl LEVEL_UNKNOWN = 3'd7;
    localparam t_lvl LEVEL_TOP     = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL6 = 3'd0,
        REG_LEVEL5 = 3'd1,
        REG_LEVEL4 = 3'd2,
        REG_LEVEL3 = 3'd3,
        REG_LEVEL2 = 3'd4,
        REG_LEVEL1 = 3'd5,
        REG_CUTOFF = 3'd6,
        REG_HYST   = 3'd7
    } t_cfg_idx;

    // level_mv[0] is the level 6 threshold, level_mv[5] the level 1 threshold
    typedef struct packed {
        t_mv [NUM_LEVELS-1:0] level_mv;
        t_mv                  cutoff_mv;
        logic [HYST_W-1:0]    hysteresis_mv;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        level_mv:      {16'd3300, 16'd3450, 16'd3600, 16'd3750, 16'd3900, 16'd4100},
        cutoff_mv:     16'd3200,
        hysteresis_mv: 12'd100
    };

    // battery_mv sits in the lowest bits
    typedef struct packed {
        logic shutdown_armed;
        logic low_warning;
        logic level_changed;
        t_lvl level;
        t_mv  battery_mv;
    } t_result;

    localparam int OUT_PAD_W = OUT_TDATA_W - $bits(t_result);

endpackage

`default_nettype wire

// ===== hdl/blm_acc.sv =====
// ----------------------------------------------------------------------------
// blm_acc: sample accumulator
// Sums NUM_SAMPLES readings and hands the group sum to a holding register.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_acc #(
    parameter int NUM_SAMPLES = 10,
    parameter int SUM_W       = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [blm_pkg::ADC_W-1:0] i_adc_mv,
    output logic                          o_sum_valid,
    input  wire logic                     i_sum_ready,
    output logic [SUM_W-1:0]              o_sum
);
    import blm_pkg::*;

    localparam int CNT_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

    logic [SUM_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_sum_valid;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_acc;
    logic             w_last;
    logic             w_take;

    assign w_last  = (r_cnt == CNT_W'(NUM_SAMPLES - 1));
    // only the closing reading of a group needs room downstream
    assign o_ready = !w_last || !r_sum_valid || i_sum_ready;
    assign w_take  = i_valid && o_ready;
    assign n_acc   = r_acc + SUM_W'(i_adc_mv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_sum_valid <= 1'b0;
        end else begin
            if (w_take && w_last) begin
                r_acc       <= '0;
                r_cnt       <= '0;
                r_sum_valid <= 1'b1;
            end else begin
                if (w_take) begin
                    r_acc <= n_acc;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (r_sum_valid && i_sum_ready) begin
                    r_sum_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_last) begin
            r_sum <= n_acc;
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_sum       = r_sum;

endmodule

`default_nettype wire

// ===== hdl/blm_scale.sv =====
// ----------------------------------------------------------------------------
// blm_scale: group sum to battery millivolts
// mv = floor(sum * RATIO / 256 / N), saturated; the divide by N is a
// multiply by a rounded-up reciprocal, exact over the whole input range.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_scale #(
    parameter int NUM_SAMPLES      = 10,
    parameter int DIVIDER_RATIO_Q8 = 512,
    parameter int SUM_W            = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [SUM_W-1:0]     i_sum,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output blm_pkg::t_mv              o_mv
);
    import blm_pkg::*;

    localparam int RATIO_W = $clog2(DIVIDER_RATIO_Q8 + 1);
    localparam int PROD_W  = SUM_W + RATIO_W;
    localparam int Q_W     = PROD_W - 8;
    localparam int NW      = $clog2(NUM_SAMPLES + 1);
    localparam int SH      = Q_W + NW;
    localparam int RECIP_W = SH + 1;
    localparam int PROD2_W = Q_W + RECIP_W;
    localparam int EXT_W   = (Q_W > MV_W) ? Q_W : MV_W + 1;
    localparam longint unsigned RECIP_L =
        ((longint'(1) << SH) + longint'(NUM_SAMPLES) - longint'(1)) / longint'(NUM_SAMPLES);
    localparam logic [RATIO_W-1:0] RATIO = RATIO_W'(DIVIDER_RATIO_Q8);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    logic               r_q_valid;
    logic [Q_W-1:0]     r_q;
    logic               r_mv_valid;
    t_mv                r_mv;
    logic               w_s3_ready;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD2_W-1:0] w_prod2;
    logic [Q_W-1:0]     w_quot;
    logic [EXT_W-1:0]   w_quot_ext;
    t_mv                n_mv;

    assign w_s3_ready = !r_mv_valid || i_ready;
    assign o_ready    = !r_q_valid || w_s3_ready;

    assign w_prod     = {{RATIO_W{1'b0}}, i_sum} * {{SUM_W{1'b0}}, RATIO};
    assign w_prod2    = {{RECIP_W{1'b0}}, r_q} * {{Q_W{1'b0}}, RECIP};
    assign w_quot     = w_prod2[SH +: Q_W];
    assign w_quot_ext = EXT_W'(w_quot);
    assign n_mv       = (w_quot_ext > EXT_W'(MV_MAX)) ? MV_MAX : w_quot_ext[MV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid  <= 1'b0;
            r_mv_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_q_valid <= i_valid;
            end
            if (w_s3_ready) begin
                r_mv_valid <= r_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_q <= w_prod[PROD_W-1:8];
        end
        if (w_s3_ready && r_q_valid) begin
            r_mv <= n_mv;
        end
    end

    assign o_valid = r_mv_valid;
    assign o_mv    = r_mv;

endmodule

`default_nettype wire

// ===== hdl/blm_class.sv =====
// ----------------------------------------------------------------------------
// blm_class: level mapping and shutdown arming
// Maps millivolts to a level, tracks level changes and the armed flag, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_class (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire blm_pkg::t_cfg    i_cfg,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire blm_pkg::t_mv     i_mv,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output blm_pkg::t_result      o_result
);
    import blm_pkg::*;

    logic              r_out_valid;
    t_result           r_result;
    t_lvl              r_last_level;
    logic              r_armed;
    t_lvl              n_level;
    logic              n_armed;
    logic              w_take;
    logic              w_low;
    logic              w_high;
    logic [MV_W:0]     w_disarm_mv;

    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // level 1 threshold first; the lowest index that matches wins
    always_comb begin
        n_level = '0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
            if (i_mv >= i_cfg.level_mv[k]) begin
                n_level = LEVEL_TOP - LVL_W'(k);
            end
        end
    end

    assign w_disarm_mv = {1'b0, i_cfg.cutoff_mv} + (MV_W+1)'(i_cfg.hysteresis_mv);
    assign w_low       = (i_mv < i_cfg.cutoff_mv) && (i_mv > MIN_VALID_MV);
    assign w_high      = ({1'b0, i_mv} > w_disarm_mv);
    assign n_armed     = w_low ? 1'b1 : (w_high ? 1'b0 : r_armed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_level <= LEVEL_UNKNOWN;
            r_armed      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (w_take) begin
                r_last_level <= n_level;
                r_armed      <= n_armed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result.battery_mv     <= i_mv;
            r_result.level          <= n_level;
            r_result.level_changed  <= (n_level != r_last_level);
            r_result.low_warning    <= w_low && !r_armed;
            r_result.shutdown_armed <= n_armed;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== hdl/battery_level_monitor_top.sv =====
// ----------------------------------------------------------------------------
// battery_level_monitor_top: averaged battery voltage and charge level
// Each input request carries one 12-bit ADC reading in mV. Every
// NUM_SAMPLES readings the group sum is scaled by DIVIDER_RATIO_Q8 / 256
// and averaged, giving battery mV saturated at 65535, then mapped through
// six configurable thresholds to a level 0..6 with low-battery arming.
// Only the closing reading of a group yields an output request.
// Throughput: one reading per cycle unless the stages ahead are stalled.
// The closing reading passes through the sum register, the ratio multiply,
// the reciprocal multiply, then the output register.
// The config port takes one write per cycle with no handshake; write it
// only while the block is idle.
// Reset (synchronous, active low) clears the running sum and count, sets
// the level to unknown so the first result flags a change, disarms the
// shutdown flag and reloads the threshold defaults.
// When the receiver stalls, each stage holds; readings keep being accepted
// until a finished group sum finds every stage ahead of it full.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_monitor_top #(
    parameter int NUM_SAMPLES      = 10,
    parameter int DIVIDER_RATIO_Q8 = 512
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [blm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [11:0] adc_mv
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [15:0] battery_mv, [18:16] level, [19] level_changed,
    // [20] low_warning, [21] shutdown_armed
    output logic [blm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [blm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [blm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import blm_pkg::*;

    // wide enough for NUM_SAMPLES full-scale readings
    localparam int SUM_W = $clog2(NUM_SAMPLES * ((1 << ADC_W) - 1) + 1);

    t_cfg             r_cfg;
    logic             w_sum_valid;
    logic             w_sum_ready;
    logic [SUM_W-1:0] w_sum;
    logic             w_mv_valid;
    logic             w_mv_ready;
    t_mv              w_mv;
    t_result          w_result;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_LEVEL6: r_cfg.level_mv[0]   <= i_cfg_data;
                REG_LEVEL5: r_cfg.level_mv[1]   <= i_cfg_data;
                REG_LEVEL4: r_cfg.level_mv[2]   <= i_cfg_data;
                REG_LEVEL3: r_cfg.level_mv[3]   <= i_cfg_data;
                REG_LEVEL2: r_cfg.level_mv[4]   <= i_cfg_data;
                REG_LEVEL1: r_cfg.level_mv[5]   <= i_cfg_data;
                REG_CUTOFF: r_cfg.cutoff_mv     <= i_cfg_data;
                REG_HYST:   r_cfg.hysteresis_mv <= i_cfg_data[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- sample accumulation ----
    blm_acc #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .SUM_W       (SUM_W)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_adc_mv    (s_axis_tdata[ADC_W-1:0]),
        .o_sum_valid (w_sum_valid),
        .i_sum_ready (w_sum_ready),
        .o_sum       (w_sum)
    );

    // ---- scaling to battery mV ----
    blm_scale #(
        .NUM_SAMPLES      (NUM_SAMPLES),
        .DIVIDER_RATIO_Q8 (DIVIDER_RATIO_Q8),
        .SUM_W            (SUM_W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sum_valid),
        .o_ready (w_sum_ready),
        .i_sum   (w_sum),
        .o_valid (w_mv_valid),
        .i_ready (w_mv_ready),
        .o_mv    (w_mv)
    );

    // ---- level, hysteresis and output register ----
    blm_class u_class (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_mv_valid),
        .o_ready  (w_mv_ready),
        .i_mv     (w_mv),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, w_result};

    // ---- assertions ----
    // a warning is only raised together with the armed flag
    a_warn_implies_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!w_result.low_warning || w_result.shutdown_armed))
        else $error("low_warning without shutdown_armed");

    // reported level stays within 0..6
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_result.level <= LEVEL_TOP))
        else $error("level out of range");

    // no stale result survives reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for battery_level_monitor_top
// Streams ADC readings into the block and checks each averaged battery
// report against a cycle-free model of the averaging, threshold mapping
// and shutdown arming logic. Runs through several threshold settings,
// with random idles on both streams, a long receiver hold and a full
// drain of the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import blm_pkg::*;

    localparam int NUM_SAMPLES      = 10;
    localparam int DIVIDER_RATIO_Q8 = 512;
    localparam int DRAIN_CYCLES     = 8;     // output lags the closing reading by the pipeline registers
    localparam int LONG_HOLD        = 300;   // receiver hold-off used to back up the block
    localparam int QUIET_LIMIT      = 2000;  // cycles with no request moving at all
    localparam int MAX_SHOWN        = 10;

    // ------------------------------------------------------------------------
    // Expected-report tracker: keeps its own copy of thresholds and group
    // state, builds one report per closing reading and checks DUT reports
    // against them in order.
    // ------------------------------------------------------------------------
    class battery_check;
        t_mv               thr_mv[NUM_LEVELS];  // [0] is the level 6 threshold
        t_mv               cutoff_mv;
        logic [HYST_W-1:0] hyst_mv;
        int unsigned       group_sum;
        int unsigned       group_cnt;
        t_lvl              prev_level;
        bit                armed;
        t_result           pending_reports[$];
        int                n_errors;

        function new();
            for (int k = 0; k < NUM_LEVELS; k++) begin
                thr_mv[k] = CFG_RESET.level_mv[k];
            end
            cutoff_mv  = CFG_RESET.cutoff_mv;
            hyst_mv    = CFG_RESET.hysteresis_mv;
            group_sum  = 0;
            group_cnt  = 0;
            prev_level = LEVEL_UNKNOWN;
            armed      = 1'b0;
            n_errors   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_CUTOFF: cutoff_mv = val;
                REG_HYST:   hyst_mv = val[HYST_W-1:0];
                default:    thr_mv[int'(idx)] = val;
            endcase
        endfunction

        function void note_reading(logic [ADC_W-1:0] adc);
            longint unsigned scaled;
            int unsigned     disarm_mv;
            t_result         r;
            group_sum += 32'(adc);
            group_cnt++;
            if (group_cnt < NUM_SAMPLES)
                return;
            scaled = (longint'(group_sum) * DIVIDER_RATIO_Q8) / (NUM_SAMPLES * 256);
            r.battery_mv = (scaled > MV_MAX) ? MV_MAX : t_mv'(scaled);
            group_sum = 0;
            group_cnt = 0;

            // walk up from level 1 so the highest-priority match is kept last
            r.level = '0;
            for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
                if (r.battery_mv >= thr_mv[k])
                    r.level = t_lvl'(NUM_LEVELS - k);
            end
            r.level_changed = (r.level != prev_level);
            prev_level      = r.level;

            // disarm point is 17 bits wide, never wraps
            disarm_mv     = 32'(cutoff_mv) + 32'(hyst_mv);
            r.low_warning = 1'b0;
            if (r.battery_mv < cutoff_mv && r.battery_mv > MIN_VALID_MV) begin
                if (!armed) begin
                    armed         = 1'b1;
                    r.low_warning = 1'b1;
                end
            end else if (32'(r.battery_mv) > disarm_mv) begin
                armed = 1'b0;
            end
            r.shutdown_armed = armed;
            pending_reports.push_back(r);
        endfunction

        function void check_report(logic [OUT_TDATA_W-1:0] data);
            t_result got;
            t_result want;
            got = t_result'(data[$bits(t_result)-1:0]);
            if (pending_reports.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("unexpected report: tdata=%h", data);
                return;
            end
            want = pending_reports.pop_front();
            if (got.battery_mv !== want.battery_mv || got.level !== want.level ||
                got.level_changed !== want.level_changed ||
                got.low_warning !== want.low_warning ||
                got.shutdown_armed !== want.shutdown_armed ||
                data[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
                n_errors++;
                if (n_errors <= MAX_SHOWN) begin
                    $display("report mismatch: exp mv=%0d lvl=%0d chg=%b warn=%b arm=%b",
                             want.battery_mv, want.level, want.level_changed,
                             want.low_warning, want.shutdown_armed);
                    $display("                 got mv=%0d lvl=%0d chg=%b warn=%b arm=%b pad=%b",
                             got.battery_mv, got.level, got.level_changed,
                             got.low_warning, got.shutdown_armed,
                             data[OUT_TDATA_W-1 -: OUT_PAD_W]);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // [11:0] adc_mv
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // [15:0] battery_mv, [18:16] level, [19] level_changed,
    // [20] low_warning, [21] shutdown_armed
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    battery_level_monitor_top #(
        .NUM_SAMPLES      (NUM_SAMPLES),
        .DIVIDER_RATIO_Q8 (DIVIDER_RATIO_Q8)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    battery_check sb = new();

    // pacing knobs shared between the stimulus and the receiver process
    bit tx_no_gap     = 1'b0;
    bit rx_no_stall   = 1'b0;
    bit long_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: both streams sampled at the rising edge. The report is checked
    // before the reading of the same edge is noted, since a report always
    // belongs to an older group.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_report(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_reading(s_axis_tdata[ADC_W-1:0]);
        end
    end

    // Watchdog: any accepted request or config write resets the count
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: a random stall before each report, none at all in no-stall
    // stretches, and one long hold on request so the pipeline backs up into
    // the input stream.
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            if (long_hold_req) begin
                stall         = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                stall = rx_no_stall ? 0 : $urandom_range(0, 5);
            end
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // ------------------------------------------------------------------------
    // Sender side tasks
    // ------------------------------------------------------------------------
    function automatic logic [ADC_W-1:0] clip_adc(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return v[ADC_W-1:0];
    endfunction

    // one reading request; valid stays up after acceptance until the next
    // falling edge decides what comes next
    task automatic send_reading(logic [ADC_W-1:0] adc);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - ADC_W){1'b0}}, adc};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering, wait for every outstanding report, then let the
    // pipeline settle so a config write cannot land on work in flight
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
    endtask

    // Settings per phase:
    //   3: all zero (everything is level 6, shutdown never arms)
    //   4: all ones (level 0 only, disarm point above 16 bits, hyst masked)
    //   6: power-on defaults written back explicitly
    //   2: thresholds in random order, random cutoff, random 16-bit hyst
    //   else: realistic descending thresholds
    task automatic apply_config(int ph);
        int                    vals[NUM_LEVELS];
        logic [CFG_DATA_W-1:0] cut;
        logic [CFG_DATA_W-1:0] hy;
        case (ph)
            3: begin
                foreach (vals[k]) vals[k] = 0;
                cut = '0;
                hy  = '0;
            end
            4: begin
                foreach (vals[k]) vals[k] = 65535;
                cut = '1;
                hy  = '1;
            end
            6: begin
                foreach (vals[k]) vals[k] = int'(CFG_RESET.level_mv[k]);
                cut = CFG_RESET.cutoff_mv;
                hy  = CFG_DATA_W'(CFG_RESET.hysteresis_mv);
            end
            2: begin
                foreach (vals[k]) vals[k] = $urandom_range(0, 9000);
                cut = CFG_DATA_W'($urandom_range(0, 8190));
                hy  = CFG_DATA_W'($urandom_range(0, 65535));
            end
            default: begin
                vals[0] = $urandom_range(3000, 8190);
                for (int k = 1; k < NUM_LEVELS; k++) begin
                    vals[k] = vals[k-1] - int'($urandom_range(0, 900));
                    if (vals[k] < 0)
                        vals[k] = 0;
                end
                cut = CFG_DATA_W'($urandom_range(600, vals[NUM_LEVELS-1]));
                hy  = (ph == 5) ? CFG_DATA_W'($urandom_range(0, 4095))
                                : CFG_DATA_W'($urandom_range(0, 800));
            end
        endcase
        for (int k = 0; k < NUM_LEVELS; k++)
            write_reg(t_cfg_idx'(k), vals[k][CFG_DATA_W-1:0]);
        write_reg(REG_CUTOFF, cut);
        write_reg(REG_HYST, hy);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random readings, mostly steady groups aimed at a threshold, the
    // cut-off, the disarm point or the near-zero limit (battery mV is twice
    // the mean reading), the rest pure noise over the full 12-bit range.
    task automatic feed_random(int n);
        int left;
        int sel;
        int anchor;
        int base;
        int spread;
        bit noise;
        left = n;
        while (left > 0) begin
            noise  = ($urandom_range(0, 9) < 3);
            sel    = $urandom_range(0, NUM_LEVELS + 2);
            if (sel < NUM_LEVELS)
                anchor = int'(sb.thr_mv[sel]);
            else if (sel == NUM_LEVELS)
                anchor = int'(sb.cutoff_mv);
            else if (sel == NUM_LEVELS + 1)
                anchor = int'(sb.cutoff_mv) + int'(sb.hyst_mv);
            else
                anchor = int'(MIN_VALID_MV);
            base   = anchor / 2 + ($urandom_range(0, 1) ? int'($urandom_range(0, 4)) - 2
                                                         : int'($urandom_range(0, 60)) - 30);
            spread = $urandom_range(0, 3);
            for (int k = 0; k < NUM_SAMPLES && left > 0; k++) begin
                if (noise)
                    send_reading(ADC_W'($urandom_range(0, 4095)));
                else
                    send_reading(clip_adc(base + int'($urandom_range(0, 2 * spread)) - spread));
                left--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // full scale, zero, the near-zero limit on both sides, first arming,
        // already armed, inside the hysteresis band, and disarm
        int dir_vals[8] = '{4095, 0, 250, 251, 1500, 1550, 1640, 1660};
        int ph;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // phase 0: power-on thresholds, directed groups then random
        foreach (dir_vals[g]) begin
            for (int k = 0; k < NUM_SAMPLES; k++)
                send_reading(clip_adc(dir_vals[g]));
        end
        feed_random(340);

        for (ph = 1; ph <= 6; ph++) begin
            settle();
            apply_config(ph);
            // phase 1 floods the input while the receiver holds off
            tx_no_gap   = (ph == 1) || ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            if (ph == 1)
                long_hold_req = 1'b1;
            case (ph)
                2: begin
                    feed_random(140);
                    settle();        // sender waits for every report mid-phase
                    feed_random(140);
                end
                3, 4: feed_random(150);
                default: feed_random(300);
            endcase
        end

        settle();
        if (sb.n_errors == 0 && sb.pending_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
